/* hdl/fsfp_pkg.sv */
// Package for the flow sensor frame parser: shared constants, codes and types.
// Used by every module in the hdl folder; depends on nothing.
package fsfp_pkg;

  // Frame geometry: bytes that follow the header byte, and named positions.
  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_X_LO   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_X_HI   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_Y_LO   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_Y_HI   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_SUM    = POS_W'(5);
  localparam logic [POS_W-1:0] POS_SAMPLE = POS_W'(6);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);

  // Configuration register file.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;
  localparam logic [CFG_DATA_W-1:0] HEADER_RST = 8'd254;
  localparam logic [CFG_DATA_W-1:0] FOOTER_RST = 8'd170;
  localparam logic [CFG_DATA_W-1:0] GAIN_RST   = 8'd26;

  // Stream widths: result fields packed into whole bytes.
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned Q_W        = 15;
  localparam int unsigned OUT_FIELDS = 2 + 16 + 16 + Q_W;
  localparam int unsigned OUT_DATA_W = ((OUT_FIELDS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SUM_ERR  = 2'd1,
    ST_FOOT_ERR = 2'd2
  } status_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] header;
    logic [CFG_DATA_W-1:0] footer;
    logic [CFG_DATA_W-1:0] gain;
  } cfg_t;

  // A completed frame, reduced to what the check stage needs.
  typedef struct packed {
    logic        sum_ok;
    logic        foot_ok;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  sample;
  } frame_t;

endpackage

/* hdl/fsfp_collect.sv */
// Frame assembly: header search, byte position tracking, byte storage and the
// checksum and footer compares. Depends on fsfp_pkg.
module fsfp_collect (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fsfp_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  in_byte_i,
  output logic                        frame_valid_o,
  input  logic                        frame_ready_i,
  output fsfp_pkg::frame_t            frame_o
);
  import fsfp_pkg::*;

  logic             seen_q, seen_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             frame_vld_q, frame_vld_d;
  frame_t           frame_q, frame_d;
  logic [7:0]       store_q [POS_X_LO:POS_SAMPLE];
  logic             in_fire, load, store_we;
  logic [7:0]       sum;

  assign in_fire = in_valid_i && in_ready_o;

  // Only a byte that would complete a frame has to wait for the frame stage.
  assign in_ready_o = !(frame_vld_q && !frame_ready_i && seen_q && (pos_q == POS_LAST));

  assign sum = store_q[POS_X_LO] + store_q[POS_X_HI] + store_q[POS_Y_LO] + store_q[POS_Y_HI];

  always_comb begin
    seen_d   = seen_q;
    pos_d    = pos_q;
    load     = 1'b0;
    store_we = 1'b0;
    if (in_fire) begin
      if (!seen_q) begin
        if (in_byte_i == cfg_i.header) begin
          seen_d = 1'b1;
          pos_d  = '0;
        end
      end else if (pos_q == POS_LAST) begin
        seen_d = 1'b0;
        pos_d  = '0;
        load   = 1'b1;
      end else begin
        pos_d    = pos_q + POS_W'(1);
        store_we = (pos_q >= POS_X_LO) && (pos_q <= POS_SAMPLE);
      end
    end
  end

  always_comb begin
    frame_d         = frame_q;
    frame_vld_d     = frame_vld_q;
    if (frame_vld_q && frame_ready_i) begin
      frame_vld_d = 1'b0;
    end
    if (load) begin
      frame_vld_d     = 1'b1;
      frame_d.sum_ok  = (sum == store_q[POS_SUM]);
      frame_d.foot_ok = (in_byte_i == cfg_i.footer);
      frame_d.x       = {store_q[POS_X_HI], store_q[POS_X_LO]};
      frame_d.y       = {store_q[POS_Y_HI], store_q[POS_Y_LO]};
      frame_d.sample  = store_q[POS_SAMPLE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      pos_q       <= '0;
      frame_vld_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      pos_q       <= pos_d;
      frame_vld_q <= frame_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    if (store_we) begin
      store_q[pos_q] <= in_byte_i;
    end
  end

  assign frame_valid_o = frame_vld_q;
  assign frame_o       = frame_q;

`ifndef SYNTH
  a_pos_needs_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != '0) |-> seen_q)
    else $error("byte position advanced outside a frame");
  a_load_sets_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> frame_vld_q)
    else $error("completed frame was not registered");
  a_frame_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_vld_q && !frame_ready_i) |=> (frame_vld_q && $stable(frame_q)))
    else $error("waiting frame was overwritten");
`endif

endmodule

/* hdl/fsfp_check.sv */
// Frame verdict, held motion values, quality low-pass filter and the result
// register. Depends on fsfp_pkg.
module fsfp_check (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [fsfp_pkg::CFG_DATA_W-1:0]   gain_i,
  input  logic                              frame_valid_i,
  output logic                              frame_ready_o,
  input  fsfp_pkg::frame_t                  frame_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fsfp_pkg::OUT_DATA_W-1:0]   out_data_o
);
  import fsfp_pkg::*;

  logic               fire, ok;
  logic               out_vld_q, out_vld_d;
  status_e            status_q, status_d;
  logic [15:0]        x_q, x_d, y_q, y_d;
  logic [Q_W-1:0]     q_q, q_d, q_filt;
  logic signed [16:0] diff;
  logic signed [25:0] prod, rnd, shifted;
  logic signed [17:0] next;

  assign frame_ready_o = !out_vld_q || out_ready_i;
  assign fire          = frame_valid_i && frame_ready_o;
  assign ok            = frame_i.sum_ok && frame_i.foot_ok;

  // q += round((sample*128 - q) * gain / 256), saturated to the Q7.8 range.
  assign diff    = $signed({2'b00, frame_i.sample, 7'b0}) - $signed({2'b00, q_q});
  assign prod    = diff * $signed({1'b0, gain_i});
  assign rnd     = prod + 26'sd128;
  assign shifted = rnd >>> 8;
  assign next    = $signed({3'b000, q_q}) + shifted[17:0];

  always_comb begin
    if (next < 0) begin
      q_filt = '0;
    end else if (next > $signed({3'b000, {Q_W{1'b1}}})) begin
      q_filt = {Q_W{1'b1}};
    end else begin
      q_filt = next[Q_W-1:0];
    end
  end

  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    q_d       = q_q;
    status_d  = status_q;
    out_vld_d = out_vld_q && !out_ready_i;
    if (fire) begin
      out_vld_d = 1'b1;
      if (!frame_i.sum_ok) begin
        status_d = ST_SUM_ERR;
      end else if (!frame_i.foot_ok) begin
        status_d = ST_FOOT_ERR;
      end else begin
        status_d = ST_OK;
        x_d      = frame_i.x;
        y_d      = frame_i.y;
        q_d      = q_filt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      x_q       <= '0;
      y_q       <= '0;
      q_q       <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      x_q       <= x_d;
      y_q       <= y_d;
      q_q       <= q_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = {{(OUT_DATA_W - OUT_FIELDS){1'b0}}, q_q, y_q, x_q, status_q};

`ifndef SYNTH
  a_sum_err_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !frame_i.sum_ok) |=> (out_vld_q && (status_q == ST_SUM_ERR)))
    else $error("checksum failure not reported");
  a_fail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !ok) |=> ($stable(x_q) && $stable(y_q) && $stable(q_q)))
    else $error("failed frame changed held values");
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("checked frame produced no result");
`endif

endmodule

/* hdl/flow_sensor_frame_parser_top.sv */
// Path: the last byte of a frame is taken into the frame register, and the checker then
// registers its result in the result register, from which the result item can be taken.
// Throughput: one byte item per cycle; a frame takes nine items including its header.
// Only the frame-completing byte waits, and only while both stages are full and the
// result is not being taken. Reset (asynchronous, active low) clears the frame search,
// held motion, filtered quality and valid flags, and loads header 254, footer 170, gain 26.
module flow_sensor_frame_parser_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [fsfp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fsfp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input stream of received bytes.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fsfp_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
  // Result stream, one item per completed frame.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] frame_status, [17:2] motion_x, [33:18] motion_y,
  // [48:34] quality_level, [55:49] zero
  output logic [fsfp_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import fsfp_pkg::*;

  // Configuration registers. Writes to an index beyond the list are ignored.
  cfg_t   cfg_q;
  logic   frame_valid, frame_ready;
  frame_t frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header <= HEADER_RST;
      cfg_q.footer <= FOOTER_RST;
      cfg_q.gain   <= GAIN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_HEADER) begin
        cfg_q.header <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_FOOTER) begin
        cfg_q.footer <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_GAIN) begin
        cfg_q.gain <= cfg_data_i;
      end
    end
  end

  // The collector finds the header, gathers the frame bytes and does the
  // checksum and footer compares as the last byte arrives.
  fsfp_collect u_collect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_byte_i     (s_axis_tdata),
    .frame_valid_o (frame_valid),
    .frame_ready_i (frame_ready),
    .frame_o       (frame)
  );

  // The checker turns a frame into a status, updates the held motion and the
  // filtered quality on success, and presents the result item.
  fsfp_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gain_i        (cfg_q.gain),
    .frame_valid_i (frame_valid),
    .frame_ready_o (frame_ready),
    .frame_i       (frame),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata)
  );

endmodule

/* tb/flow_sensor_frame_parser_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for flow_sensor_frame_parser_top: byte stream in, frame results out.
// Depends on fsfp_pkg and the parser RTL; needs no files or arguments at run time.
module flow_sensor_frame_parser_top_tb;
  import fsfp_pkg::*;

  // A result is valid once the frame-completing byte has passed the frame and result registers.
  localparam int RESULT_LATENCY = 2;
  // Bytes offered per random phase before the settings change.
  localparam int PHASE_BYTES    = 105;
  localparam int NUM_PHASES     = 6;
  // Cycles for which the receiver refuses results during the back-pressure phase.
  localparam int HOLD_OFF_CYCLES = 80;
  // Register index with no register behind it; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // One frame result, held in the same field widths as the result stream.
  typedef struct packed {
    status_e     status;
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] q;
  } frame_result_t;

  // One row of the directed table: the byte to send and, where the outcome is
  // obvious, the result that its frame must produce.
  typedef struct packed {
    logic [7:0]    rx;
    bit            typed;
    frame_result_t want;
  } stim_row_t;

  localparam frame_result_t NO_RESULT = '0;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [7:0] rx_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [1:0] frame_status, [17:2] motion_x, [33:18] motion_y, [48:34] quality_level
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Parser state as the testbench believes it to be.
  bit             in_frame;
  int             frame_pos;
  logic [7:0]     frame_bytes [FRAME_BYTES];
  logic [15:0]    last_x;
  logic [15:0]    last_y;
  logic [14:0]    quality_q;
  logic [7:0]     hdr_cfg;
  logic [7:0]     ftr_cfg;
  logic [7:0]     gain_cfg;

  frame_result_t  pending_frames [$];
  int             fail_count  = 0;
  int             bytes_sent  = 0;
  bit             calm        = 1'b0;   // no idling on either side while set
  bit             hold_off_req = 1'b0;  // asks the receiver for one long refusal

  // Directed bytes, sent straight after reset with the default settings.
  // The first two frames fail, so the held values are still the reset zeros.
  stim_row_t directed_rows [28] = '{
    '{8'h55, 1'b0, NO_RESULT},   // line noise while searching is dropped
    '{8'hFE, 1'b0, NO_RESULT},   // header
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h02, 1'b0, NO_RESULT},
    '{8'h03, 1'b0, NO_RESULT},
    '{8'h04, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},   // sum of 1..4 is 0x0A, so the checksum fails
    '{8'hFF, 1'b0, NO_RESULT},
    // Footer also wrong: a checksum failure takes priority.
    '{8'h00, 1'b1, '{ST_SUM_ERR, 16'h0000, 16'h0000, 15'h0000}},
    '{8'hFE, 1'b0, NO_RESULT},   // header
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFC, 1'b0, NO_RESULT},   // wrapped sum matches
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hAB, 1'b1, '{ST_FOOT_ERR, 16'h0000, 16'h0000, 15'h0000}},
    '{8'hFE, 1'b0, NO_RESULT},   // header
    '{8'hFE, 1'b0, NO_RESULT},   // header value inside a frame is plain data
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h80, 1'b0, NO_RESULT},   // X = most negative
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h7F, 1'b0, NO_RESULT},   // Y = most positive
    '{8'hFE, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},   // largest quality sample
    '{8'hAA, 1'b0, NO_RESULT}    // good frame, checked against the predictor
  };

  flow_sensor_frame_parser_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advances the predicted parser by one accepted byte. Returns 1 when the byte
  // completes a frame, with the result that frame must produce.
  function automatic bit parse_rx_byte(input logic [7:0] b, output frame_result_t res);
    logic [7:0] sum;
    int         target;
    int         diff;
    int         prod;
    int         next_q;
    res = NO_RESULT;
    if (!in_frame) begin
      if (b == hdr_cfg) begin
        in_frame  = 1'b1;
        frame_pos = 0;
      end
      return 1'b0;
    end
    frame_bytes[frame_pos] = b;
    if (frame_pos < FRAME_BYTES - 1) begin
      frame_pos++;
      return 1'b0;
    end
    in_frame  = 1'b0;
    frame_pos = 0;
    sum = frame_bytes[1] + frame_bytes[2] + frame_bytes[3] + frame_bytes[4];
    if (sum != frame_bytes[5]) begin
      res.status = ST_SUM_ERR;
    end else if (frame_bytes[7] != ftr_cfg) begin
      res.status = ST_FOOT_ERR;
    end else begin
      res.status = ST_OK;
      last_x = {frame_bytes[2], frame_bytes[1]};
      last_y = {frame_bytes[4], frame_bytes[3]};
      // Target is sample/2 in Q7.8; the Q.16 step is rounded half up to Q7.8.
      target = int'(frame_bytes[6]) * 128;
      diff   = target - int'(quality_q);
      prod   = diff * int'(gain_cfg) + 128;
      next_q = int'(quality_q) + (prod >>> 8);
      if (next_q < 0) begin
        next_q = 0;
      end
      if (next_q > 32767) begin
        next_q = 32767;
      end
      quality_q = next_q[14:0];
    end
    res.x = last_x;
    res.y = last_y;
    res.q = quality_q;
    return 1'b1;
  endfunction

  // Offers one byte, with random idle cycles ahead of it, and records what it
  // should produce once the block takes it. Entered just after a rising edge.
  task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_t want);
    frame_result_t res;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (parse_rx_byte(b, res)) begin
      pending_frames.push_back(typed ? want : res);
    end
  endtask

  // Bytes lean towards the extremes so that sign and carry cases come up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Sends one random frame: mostly well formed, otherwise a bad checksum, a bad
  // footer, a burst of line noise or a frame cut short.
  task automatic send_frame();
    logic [7:0] body [FRAME_BYTES];
    int         kind;
    int         len;
    kind = $urandom_range(99);
    if (kind >= 88 && kind < 94) begin
      repeat ($urandom_range(1, 4)) send_byte(pick_byte(), 1'b0, NO_RESULT);
      return;
    end
    for (int i = 0; i < FRAME_BYTES; i++) begin
      body[i] = pick_byte();
    end
    body[5] = body[1] + body[2] + body[3] + body[4];
    body[7] = ftr_cfg;
    if (kind >= 70 && kind < 80) begin
      body[5] ^= 8'($urandom_range(1, 255));
      if ($urandom_range(1) == 1) begin
        body[7] = pick_byte();
      end
    end else if (kind >= 80 && kind < 88) begin
      body[7] ^= 8'($urandom_range(1, 255));
    end
    len = (kind >= 94) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
    send_byte(hdr_cfg, 1'b0, NO_RESULT);
    for (int i = 0; i < len; i++) begin
      send_byte(body[i], 1'b0, NO_RESULT);
    end
  endtask

  // Drives one register write for a single cycle; entered at a falling edge.
  // The caller lowers the write enable after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_HEADER: hdr_cfg  = data;
      CFG_FOOTER: ftr_cfg  = data;
      CFG_GAIN:   gain_cfg = data;
      default:    ;   // no register at this index
    endcase
    @(negedge clk_i);
  endtask

  // Receiver: refuses results about a quarter of the time, never while calm,
  // and once for a long stretch so that the parser fills and stalls its input.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  // Every result taken from the block is compared with the oldest one predicted.
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_frames.size() == 0) begin
        fail_count++;
        $display("%0t: result with none expected, got %h", $time, m_axis_tdata);
      end else begin
        want = pending_frames.pop_front();
        if (m_axis_tdata[1:0] !== want.status) begin
          fail_count++;
          $display("%0t: frame_status expected %0d, got %0d",
                   $time, want.status, m_axis_tdata[1:0]);
        end
        if (m_axis_tdata[17:2] !== want.x) begin
          fail_count++;
          $display("%0t: motion_x expected %h, got %h", $time, want.x, m_axis_tdata[17:2]);
        end
        if (m_axis_tdata[33:18] !== want.y) begin
          fail_count++;
          $display("%0t: motion_y expected %h, got %h", $time, want.y, m_axis_tdata[33:18]);
        end
        if (m_axis_tdata[48:34] !== want.q) begin
          fail_count++;
          $display("%0t: quality_level expected %h, got %h",
                   $time, want.q, m_axis_tdata[48:34]);
        end
      end
    end
  end

  // Stimulus: directed table, then phases of random frames under changing settings.
  initial begin
    int         phase_start;
    logic [7:0] hdr_next;
    logic [7:0] ftr_next;
    logic [7:0] gain_next;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_HEADER;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    in_frame      = 1'b0;
    frame_pos     = 0;
    last_x        = '0;
    last_y        = '0;
    quality_q     = '0;
    hdr_cfg       = HEADER_RST;
    ftr_cfg       = FOOTER_RST;
    gain_cfg      = GAIN_RST;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(directed_rows); i++) begin
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Leave a frame half received, so that the new settings apply mid-frame.
      send_byte(hdr_cfg, 1'b0, NO_RESULT);
      repeat (3) send_byte(pick_byte(), 1'b0, NO_RESULT);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      // Registers change only once every result is out and the pipeline is empty.
      while (pending_frames.size() != 0) @(negedge clk_i);
      repeat (RESULT_LATENCY + 2) @(negedge clk_i);

      case (p)
        0: begin
          hdr_next = 8'h00; ftr_next = 8'hFF; gain_next = 8'hFF;
        end
        1: begin
          hdr_next = 8'hFF; ftr_next = 8'h00; gain_next = 8'h00;
        end
        2: begin
          hdr_next = 8'($urandom); ftr_next = 8'($urandom); gain_next = 8'h80;
        end
        3: begin
          hdr_next = HEADER_RST; ftr_next = FOOTER_RST; gain_next = GAIN_RST;
        end
        default: begin
          hdr_next = 8'($urandom); ftr_next = 8'($urandom); gain_next = 8'($urandom);
        end
      endcase
      write_reg(CFG_HEADER, hdr_next);
      write_reg(CFG_FOOTER, ftr_next);
      write_reg(CFG_GAIN, gain_next);
      if (p == 2) begin
        write_reg(CFG_SPARE, 8'($urandom));
      end
      cfg_we_i <= 1'b0;

      // Phase 1 holds results back for a long while; phase 3 runs flat out.
      hold_off_req = (p == 1);
      calm         = (p == 3);
      phase_start  = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_frame();
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    // Wait on, to catch any result that should not exist.
    repeat (RESULT_LATENCY + 8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("flow_sensor_frame_parser_top regression: pass");
    end else begin
      $display("flow_sensor_frame_parser_top regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("flow_sensor_frame_parser_top regression: fail");
    $finish;
  end

endmodule
